// File: design/relative_pose_from_axis_angle_defines.svh
// Assertion macros used by the relative pose top level.
`ifndef RELATIVE_POSE_FROM_AXIS_ANGLE_DEFINES_SVH
`define RELATIVE_POSE_FROM_AXIS_ANGLE_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define RPAA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpaa assertion failed");
// Condition must never be seen.
`define RPAA_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rpaa assertion failed");
`else
`define RPAA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RPAA_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// File: design/rpaa_pkg.sv
// Shared constants, types and tables for the relative pose pipeline.
package rpaa_pkg;

  // CORDIC iterations (12..32)
  localparam int CORDIC_STAGES = 18;

  // Field widths
  localparam int ROT_W   = 18;  // rotation vector, Q3.14
  localparam int SHIFT_W = 32;  // translation, Q15.16
  localparam int OUT_W   = 18;  // rotation output, Q1.16

  // Internal widths
  localparam int RAD_W      = 40;        // 16*|v|^2
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int THETA_W    = 20;        // |v| in Q.16
  localparam int MAG_W      = 18;        // |v_i|
  localparam int QUO_W      = 31;        // axis quotient, <= 2^30
  localparam int REM_W      = 21;
  localparam int AXIS_W     = 32;        // axis component, Q.30
  localparam int CS_W       = 34;        // CORDIC datapath, Q.30
  localparam int ANG_W      = 37;        // unreduced angle, Q.30
  localparam int MAT_W      = 32;        // matrix entry, Q.30

  // Pipeline latencies
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_LAT    = QUO_W + 2;
  localparam int CS_LAT     = CORDIC_STAGES + 4;
  localparam int BRANCH_LAT = (DIV_LAT > CS_LAT) ? DIV_LAT : CS_LAT;
  localparam int MAT_LAT    = 3;
  localparam int ROD_LAT    = SQRT_LAT + BRANCH_LAT + MAT_LAT;
  localparam int COMP_LAT   = 4;
  localparam int TOTAL_LAT  = ROD_LAT + COMP_LAT;

  // Angle constants, Q.30
  localparam logic signed [ANG_W-1:0] PI30          = 37'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI30      = 37'sd6746518852;
  localparam logic signed [ANG_W-1:0] THREE_PI30    = 37'sd10119778278;
  localparam logic signed [ANG_W-1:0] FOUR_PI30     = 37'sd13493037704;
  localparam logic signed [ANG_W-1:0] HALF_PI30     = 37'sd1686629713;
  localparam logic signed [ANG_W-1:0] NEG_HALF_PI30 = -37'sd1686629713;

  localparam logic signed [CS_W-1:0]  GAIN30    = 34'sd652032874;
  localparam logic signed [CS_W-1:0]  ONE30_CS  = 34'sd1073741824;
  localparam logic signed [MAT_W-1:0] ONE30     = 32'sd1073741824;
  localparam logic signed [MAT_W-1:0] NEG_ONE30 = -32'sd1073741824;

  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic signed [OUT_W-1:0]   out_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [CS_W-1:0]    cs_t;
  typedef logic signed [ANG_W-1:0]   ang_t;
  typedef logic signed [MAT_W-1:0]   mat_t;

  // Control travelling with each transaction
  typedef struct packed {
    logic valid;
    logic ident;   // zero rotation vector
  } ctl_t;

  // atan(2^-i) in Q.30
  function automatic cs_t atan_q30(input int idx);
    unique case (idx)
      0:  return 34'sd843314857;
      1:  return 34'sd497837829;
      2:  return 34'sd263043837;
      3:  return 34'sd133525159;
      4:  return 34'sd67021687;
      5:  return 34'sd33543516;
      6:  return 34'sd16775851;
      7:  return 34'sd8388437;
      8:  return 34'sd4194283;
      9:  return 34'sd2097149;
      10: return 34'sd1048576;
      11: return 34'sd524288;
      12: return 34'sd262144;
      13: return 34'sd131072;
      14: return 34'sd65536;
      15: return 34'sd32768;
      16: return 34'sd16384;
      17: return 34'sd8192;
      18: return 34'sd4096;
      19: return 34'sd2048;
      20: return 34'sd1024;
      21: return 34'sd512;
      22: return 34'sd256;
      23: return 34'sd128;
      24: return 34'sd64;
      25: return 34'sd32;
      26: return 34'sd16;
      27: return 34'sd8;
      28: return 34'sd4;
      29: return 34'sd2;
      30: return 34'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// File: design/rpaa_isqrt.sv
// Pipelined squared norm and integer square root of a rotation vector.
module rpaa_isqrt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  rpaa_pkg::rot_t                      v [3],
  output rpaa_pkg::ctl_t                      ctl,
  output rpaa_pkg::rot_t                      v_out [3],
  output logic [rpaa_pkg::THETA_W-1:0]        theta
);
  localparam int N = rpaa_pkg::SQRT_STEPS;
  localparam int W = rpaa_pkg::RAD_W;
  localparam int SQ_W = 2 * rpaa_pkg::ROT_W;

  logic [W-1:0]   rad_next;
  logic [W-1:0]   rem  [N+1];
  logic [W-1:0]   root [N+1];
  rpaa_pkg::ctl_t cs   [N+1];
  rpaa_pkg::rot_t vs   [N+1][3];

  // 16 * (vx^2 + vy^2 + vz^2)
  always_comb begin
    logic signed [SQ_W-1:0] sq0, sq1, sq2;
    sq0 = v[0] * v[0];
    sq1 = v[1] * v[1];
    sq2 = v[2] * v[2];
    rad_next = (W'(unsigned'(sq0)) + W'(unsigned'(sq1)) + W'(unsigned'(sq2))) << 4;
  end

  always_ff @(posedge clk) begin
    rem[0]  <= rad_next;
    root[0] <= '0;
    vs[0]   <= v;
    if (rst) begin
      cs[0] <= '0;
    end else begin
      cs[0] <= '{valid: in_valid, ident: (rad_next == '0)};
    end
  end

  // One root bit per stage
  for (genvar s = 0; s < N; s++) begin : g_step
    localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2*s);
    logic [W:0]   trial;
    logic [W-1:0] rem_next, root_next;

    always_comb begin
      trial = {1'b0, root[s]} + BIT;
      if ({1'b0, rem[s]} >= trial) begin
        rem_next  = W'({1'b0, rem[s]} - trial);
        root_next = W'(({1'b0, root[s]} >> 1) + BIT);
      end else begin
        rem_next  = rem[s];
        root_next = root[s] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1]  <= rem_next;
      root[s+1] <= root_next;
      vs[s+1]   <= vs[s];
      if (rst) begin
        cs[s+1] <= '0;
      end else begin
        cs[s+1] <= cs[s];
      end
    end
  end

  assign ctl   = cs[N];
  assign v_out = vs[N];
  assign theta = root[N][rpaa_pkg::THETA_W-1:0];

endmodule

// File: design/rpaa_div.sv
// Pipelined restoring divider: axis component k = v * 2^32 / theta.
module rpaa_div (
  input  logic                         clk,
  input  logic [rpaa_pkg::MAG_W-1:0]   mag,
  input  logic                         neg,
  input  logic [rpaa_pkg::THETA_W-1:0] theta,
  output rpaa_pkg::axis_t              k
);
  localparam int N   = rpaa_pkg::QUO_W;
  localparam int RW  = rpaa_pkg::REM_W;
  localparam int PAD = rpaa_pkg::BRANCH_LAT - rpaa_pkg::DIV_LAT;

  logic [RW-1:0]                 rem [N+1];
  logic [N-1:0]                  quo [N+1];
  logic [rpaa_pkg::THETA_W-1:0]  th  [N+1];
  logic                          sg  [N+1];
  rpaa_pkg::axis_t               k_r;

  // theta >= 4|v|, so 2|v| is already below the divisor
  always_ff @(posedge clk) begin
    rem[0] <= RW'({mag, 1'b0});
    quo[0] <= '0;
    th[0]  <= theta;
    sg[0]  <= neg;
  end

  // One quotient bit per stage; low dividend bits are all zero
  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [RW-1:0] sh;
    assign sh = {rem[i][RW-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (sh >= RW'(th[i])) begin
        rem[i+1] <= sh - RW'(th[i]);
        quo[i+1] <= {quo[i][N-2:0], 1'b1};
      end else begin
        rem[i+1] <= sh;
        quo[i+1] <= {quo[i][N-2:0], 1'b0};
      end
      th[i+1] <= th[i];
      sg[i+1] <= sg[i];
    end
  end

  // Sign back on, rounding toward zero; |k| <= 2^30 needs no clamp
  always_ff @(posedge clk) begin
    k_r <= sg[N] ? -rpaa_pkg::axis_t'(quo[N]) : rpaa_pkg::axis_t'(quo[N]);
  end

  // Align with the angle branch
  if (PAD == 0) begin : g_nopad
    assign k = k_r;
  end else begin : g_pad
    rpaa_pkg::axis_t dl [PAD];
    always_ff @(posedge clk) begin
      dl[0] <= k_r;
      for (int p = 1; p < PAD; p++) dl[p] <= dl[p-1];
    end
    assign k = dl[PAD-1];
  end

endmodule

// File: design/rpaa_cordic.sv
// Angle reduction and pipelined CORDIC giving cos and sin in Q.30.
module rpaa_cordic (
  input  logic                         clk,
  input  logic [rpaa_pkg::THETA_W-1:0] theta,
  output rpaa_pkg::cs_t                c,
  output rpaa_pkg::cs_t                s
);
  localparam int N   = rpaa_pkg::CORDIC_STAGES;
  localparam int AW  = rpaa_pkg::ANG_W;
  localparam int CW  = rpaa_pkg::CS_W;
  localparam int PAD = rpaa_pkg::BRANCH_LAT - rpaa_pkg::CS_LAT;

  rpaa_pkg::ang_t ath, a1, a2, zf;
  logic           fl;
  rpaa_pkg::cs_t  x [N+1];
  rpaa_pkg::cs_t  y [N+1];
  rpaa_pkg::cs_t  z [N+1];
  logic           flip [N+1];
  rpaa_pkg::cs_t  c_r, s_r;

  // theta in Q.16 to Q.30
  assign ath = AW'({theta, 14'b0});

  // Whole-turn reduction: theta stays below 5*pi, so at most two turns
  always_ff @(posedge clk) begin
    a1 <= (ath > rpaa_pkg::THREE_PI30) ? ath - rpaa_pkg::FOUR_PI30 : ath;
    a2 <= (a1 > rpaa_pkg::PI30) ? a1 - rpaa_pkg::TWO_PI30 : a1;
  end

  // Fold into [-pi/2, pi/2]; flipped angles negate cos and sin
  always_comb begin
    if (a2 > rpaa_pkg::HALF_PI30) begin
      zf = a2 - rpaa_pkg::PI30;
      fl = 1'b1;
    end else if (a2 < rpaa_pkg::NEG_HALF_PI30) begin
      zf = a2 + rpaa_pkg::PI30;
      fl = 1'b1;
    end else begin
      zf = a2;
      fl = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x[0]    <= rpaa_pkg::GAIN30;
    y[0]    <= '0;
    z[0]    <= CW'(zf);
    flip[0] <= fl;
  end

  // Rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam rpaa_pkg::cs_t ATAN = rpaa_pkg::atan_q30(i);
    always_ff @(posedge clk) begin
      if (!z[i][CW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN;
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN;
      end
      flip[i+1] <= flip[i];
    end
  end

  always_ff @(posedge clk) begin
    c_r <= flip[N] ? -x[N] : x[N];
    s_r <= flip[N] ? -y[N] : y[N];
  end

  // Align with the divider branch
  if (PAD == 0) begin : g_nopad
    assign c = c_r;
    assign s = s_r;
  end else begin : g_pad
    rpaa_pkg::cs_t dc [PAD];
    rpaa_pkg::cs_t ds [PAD];
    always_ff @(posedge clk) begin
      dc[0] <= c_r;
      ds[0] <= s_r;
      for (int p = 1; p < PAD; p++) begin
        dc[p] <= dc[p-1];
        ds[p] <= ds[p-1];
      end
    end
    assign c = dc[PAD-1];
    assign s = ds[PAD-1];
  end

endmodule

// File: design/rpaa_rodrigues.sv
// Rodrigues rotation matrix from norm, axis division and CORDIC results.
module rpaa_rodrigues (
  input  logic                         clk,
  input  logic                         rst,
  input  rpaa_pkg::ctl_t               ctl_in,
  input  rpaa_pkg::rot_t               v [3],
  input  logic [rpaa_pkg::THETA_W-1:0] theta,
  output rpaa_pkg::ctl_t               ctl_out,
  output rpaa_pkg::mat_t               m [9]
);
  localparam int BL    = rpaa_pkg::BRANCH_LAT;
  localparam int CW    = rpaa_pkg::CS_W;
  localparam int KW    = rpaa_pkg::AXIS_W;
  localparam int MW    = rpaa_pkg::MAT_W;
  localparam int SUM_W = CW + 2;

  rpaa_pkg::axis_t k [3];
  rpaa_pkg::cs_t   c, s;
  rpaa_pkg::ctl_t  cd [BL];
  rpaa_pkg::ctl_t  ca, cb, cc;

  // Axis components
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [rpaa_pkg::MAG_W-1:0] mag;
    assign mag = v[i][rpaa_pkg::ROT_W-1] ? rpaa_pkg::MAG_W'(-v[i])
                                         : rpaa_pkg::MAG_W'(v[i]);
    rpaa_div u_div (
      .clk   (clk),
      .mag   (mag),
      .neg   (v[i][rpaa_pkg::ROT_W-1]),
      .theta (theta),
      .k     (k[i])
    );
  end

  rpaa_cordic u_cordic (
    .clk   (clk),
    .theta (theta),
    .c     (c),
    .s     (s)
  );

  // Control alongside the two branches
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < BL; p++) cd[p] <= '0;
    end else begin
      cd[0] <= ctl_in;
      for (int p = 1; p < BL; p++) cd[p] <= cd[p-1];
    end
  end

  // Stage A: k*k^T, s*k, 1-c
  rpaa_pkg::mat_t kk_next [9];
  rpaa_pkg::cs_t  sk_next [3];
  rpaa_pkg::mat_t kka [9];
  rpaa_pkg::cs_t  ska [3];
  rpaa_pkg::cs_t  ta, cva;

  always_comb begin
    logic signed [2*KW-1:0]  pkk;
    logic signed [CW+KW-1:0] psk;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pkk = k[i] * k[j];
        kk_next[i*3+j] = pkk[MW+29:30];
      end
      psk = s * k[i];
      sk_next[i] = psk[CW+29:30];
    end
  end

  always_ff @(posedge clk) begin
    kka <= kk_next;
    ska <= sk_next;
    ta  <= rpaa_pkg::ONE30_CS - c;
    cva <= c;
    if (rst) ca <= '0;
    else     ca <= cd[BL-1];
  end

  // Stage B: (1-c)*k*k^T
  rpaa_pkg::cs_t e_next [9];
  rpaa_pkg::cs_t eb [9];
  rpaa_pkg::cs_t skb [3];
  rpaa_pkg::cs_t cvb;

  always_comb begin
    logic signed [CW+MW-1:0] pe;
    for (int n = 0; n < 9; n++) begin
      pe = ta * kka[n];
      e_next[n] = pe[CW+29:30];
    end
  end

  always_ff @(posedge clk) begin
    eb  <= e_next;
    skb <= ska;
    cvb <= cva;
    if (rst) cb <= '0;
    else     cb <= ca;
  end

  // Stage C: add cos on the diagonal and the skew terms, clamp; identity for a zero vector
  logic signed [SUM_W-1:0] sm [9];
  rpaa_pkg::mat_t          m_next [9];

  always_comb begin
    for (int n = 0; n < 9; n++) sm[n] = SUM_W'(eb[n]);
    sm[0] = sm[0] + SUM_W'(cvb);
    sm[4] = sm[4] + SUM_W'(cvb);
    sm[8] = sm[8] + SUM_W'(cvb);
    sm[1] = sm[1] - SUM_W'(skb[2]);
    sm[2] = sm[2] + SUM_W'(skb[1]);
    sm[3] = sm[3] + SUM_W'(skb[2]);
    sm[5] = sm[5] - SUM_W'(skb[0]);
    sm[6] = sm[6] - SUM_W'(skb[1]);
    sm[7] = sm[7] + SUM_W'(skb[0]);
    for (int n = 0; n < 9; n++) begin
      if (cb.ident) begin
        m_next[n] = (n % 4 == 0) ? rpaa_pkg::ONE30 : '0;
      end else if (sm[n] > SUM_W'(rpaa_pkg::ONE30)) begin
        m_next[n] = rpaa_pkg::ONE30;
      end else if (sm[n] < SUM_W'(rpaa_pkg::NEG_ONE30)) begin
        m_next[n] = rpaa_pkg::NEG_ONE30;
      end else begin
        m_next[n] = MW'(sm[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    m <= m_next;
    if (rst) cc <= '0;
    else     cc <= cb;
  end

  assign ctl_out = cc;

endmodule

// File: design/rpaa_compose.sv
// Relative rotation R2*R1^T and translation T2 - Rrel*T1, four stages.
module rpaa_compose (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rpaa_pkg::mat_t    r1 [9],
  input  rpaa_pkg::mat_t    r2 [9],
  input  rpaa_pkg::shift_t  t1 [3],
  input  rpaa_pkg::shift_t  t2 [3],
  output logic              out_valid,
  output rpaa_pkg::out_t    rel_r [9],
  output rpaa_pkg::shift_t  rel_t [3]
);
  localparam int MW    = rpaa_pkg::MAT_W;
  localparam int SW    = rpaa_pkg::SHIFT_W;
  localparam int PW    = 2 * MW;
  localparam int ACC_W = PW + 2;
  localparam int SH_W  = ACC_W - 30;
  localparam int DW    = SH_W + 1;
  localparam logic signed [ACC_W-1:0] ROUND30 = ACC_W'(1) <<< 29;

  logic [3:0] vld;

  // Stage 1: rotation products
  logic signed [PW-1:0] p [9][3];
  rpaa_pkg::shift_t     t1a [3];
  rpaa_pkg::shift_t     t2a [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int q = 0; q < 3; q++)
          p[i*3+j][q] <= PW'(r2[i*3+q] * r1[j*3+q]);
    t1a <= t1;
    t2a <= t2;
  end

  // Stage 2: sum, round, clamp to Q.30, scale to Q1.16
  rpaa_pkg::mat_t rr_next [9];
  rpaa_pkg::out_t ent_next [9];
  rpaa_pkg::mat_t rrb [9];
  rpaa_pkg::out_t entb [9];
  rpaa_pkg::shift_t t1b [3];
  rpaa_pkg::shift_t t2b [3];

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [SH_W-1:0]  sh;
    logic signed [MW:0]      rnd;
    for (int n = 0; n < 9; n++) begin
      acc = ACC_W'(p[n][0]) + ACC_W'(p[n][1]) + ACC_W'(p[n][2]) + ROUND30;
      sh  = acc[ACC_W-1:30];
      if (sh > SH_W'(rpaa_pkg::ONE30))           rr_next[n] = rpaa_pkg::ONE30;
      else if (sh < SH_W'(rpaa_pkg::NEG_ONE30))  rr_next[n] = rpaa_pkg::NEG_ONE30;
      else                                       rr_next[n] = MW'(sh);
      rnd = (MW+1)'(rr_next[n]) + (MW+1)'(8192);
      ent_next[n] = rnd[MW-1:14];
    end
  end

  always_ff @(posedge clk) begin
    rrb  <= rr_next;
    entb <= ent_next;
    t1b  <= t1a;
    t2b  <= t2a;
  end

  // Stage 3: Rrel*T1 products
  logic signed [PW-1:0] pt [3][3];
  rpaa_pkg::out_t       entc [9];
  rpaa_pkg::shift_t     t2c [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      for (int q = 0; q < 3; q++)
        pt[i][q] <= PW'(rrb[i*3+q] * t1b[q]);
    entc <= entb;
    t2c  <= t2b;
  end

  // Stage 4: round, subtract from T2, saturate
  rpaa_pkg::shift_t tr_next [3];

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [DW-1:0]    d;
    for (int i = 0; i < 3; i++) begin
      acc = ACC_W'(pt[i][0]) + ACC_W'(pt[i][1]) + ACC_W'(pt[i][2]) + ROUND30;
      d   = DW'(t2c[i]) - DW'($signed(acc[ACC_W-1:30]));
      if (d > DW'(32'sh7FFFFFFF))       tr_next[i] = 32'sh7FFFFFFF;
      else if (d < -DW'(33'sh80000000)) tr_next[i] = 32'sh80000000;
      else                              tr_next[i] = SW'(d);
    end
  end

  always_ff @(posedge clk) begin
    rel_r <= entc;
    rel_t <= tr_next;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[2:0], in_valid};
  end

  assign out_valid = vld[3];

endmodule

// File: design/relative_pose_from_axis_angle.sv
// Top level: relative pose of two axis-angle camera poses.
//
//  channel   direction  handshake              payload
//  command   in         start, busy            first_*/second_* rot and shift
//  result    out        done (one-cycle)       rel_r00..rel_r22, rel_shift_*
//
// One transaction may enter every cycle; busy is never raised.
// The path runs through the square root, then the axis divider and CORDIC
// side by side, the shorter padded to the longer, then the matrix build and
// the composition.
// Synchronous reset clears only the control bits (valid and zero-vector flag); results leave in order.
`include "relative_pose_from_axis_angle_defines.svh"
module relative_pose_from_axis_angle (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  output logic                    done,
  input  logic signed [17:0]      first_rot_x,
  input  logic signed [17:0]      first_rot_y,
  input  logic signed [17:0]      first_rot_z,
  input  logic signed [31:0]      first_shift_x,
  input  logic signed [31:0]      first_shift_y,
  input  logic signed [31:0]      first_shift_z,
  input  logic signed [17:0]      second_rot_x,
  input  logic signed [17:0]      second_rot_y,
  input  logic signed [17:0]      second_rot_z,
  input  logic signed [31:0]      second_shift_x,
  input  logic signed [31:0]      second_shift_y,
  input  logic signed [31:0]      second_shift_z,
  output logic signed [17:0]      rel_r00,
  output logic signed [17:0]      rel_r01,
  output logic signed [17:0]      rel_r02,
  output logic signed [17:0]      rel_r10,
  output logic signed [17:0]      rel_r11,
  output logic signed [17:0]      rel_r12,
  output logic signed [17:0]      rel_r20,
  output logic signed [17:0]      rel_r21,
  output logic signed [17:0]      rel_r22,
  output logic signed [31:0]      rel_shift_x,
  output logic signed [31:0]      rel_shift_y,
  output logic signed [31:0]      rel_shift_z
);
  localparam int RL = rpaa_pkg::ROD_LAT;

  rpaa_pkg::rot_t   v1 [3];
  rpaa_pkg::rot_t   v2 [3];
  rpaa_pkg::rot_t   v1q [3];
  rpaa_pkg::rot_t   v2q [3];
  rpaa_pkg::ctl_t   q1, q2, ctl1, ctl2;
  logic [rpaa_pkg::THETA_W-1:0] th1, th2;
  rpaa_pkg::mat_t   m1 [9];
  rpaa_pkg::mat_t   m2 [9];
  rpaa_pkg::shift_t t1d [RL][3];
  rpaa_pkg::shift_t t2d [RL][3];
  rpaa_pkg::out_t   rr [9];
  rpaa_pkg::shift_t tr [3];
  logic             accept;

  // Fully pipelined: never back-pressures
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign v1[0] = first_rot_x;
  assign v1[1] = first_rot_y;
  assign v1[2] = first_rot_z;
  assign v2[0] = second_rot_x;
  assign v2[1] = second_rot_y;
  assign v2[2] = second_rot_z;

  // Norms
  rpaa_isqrt u_sqrt1 (
    .clk (clk), .rst (rst), .in_valid (accept), .v (v1),
    .ctl (q1), .v_out (v1q), .theta (th1)
  );
  rpaa_isqrt u_sqrt2 (
    .clk (clk), .rst (rst), .in_valid (accept), .v (v2),
    .ctl (q2), .v_out (v2q), .theta (th2)
  );

  // Rotation matrices
  rpaa_rodrigues u_rod1 (
    .clk (clk), .rst (rst), .ctl_in (q1), .v (v1q), .theta (th1),
    .ctl_out (ctl1), .m (m1)
  );
  rpaa_rodrigues u_rod2 (
    .clk (clk), .rst (rst), .ctl_in (q2), .v (v2q), .theta (th2),
    .ctl_out (ctl2), .m (m2)
  );

  // Translations wait for the matrices
  always_ff @(posedge clk) begin
    t1d[0][0] <= first_shift_x;
    t1d[0][1] <= first_shift_y;
    t1d[0][2] <= first_shift_z;
    t2d[0][0] <= second_shift_x;
    t2d[0][1] <= second_shift_y;
    t2d[0][2] <= second_shift_z;
    for (int p = 1; p < RL; p++) begin
      t1d[p] <= t1d[p-1];
      t2d[p] <= t2d[p-1];
    end
  end

  // Composition
  rpaa_compose u_comp (
    .clk (clk), .rst (rst), .in_valid (ctl1.valid),
    .r1 (m1), .r2 (m2), .t1 (t1d[RL-1]), .t2 (t2d[RL-1]),
    .out_valid (done), .rel_r (rr), .rel_t (tr)
  );

  assign rel_r00     = rr[0];
  assign rel_r01     = rr[1];
  assign rel_r02     = rr[2];
  assign rel_r10     = rr[3];
  assign rel_r11     = rr[4];
  assign rel_r12     = rr[5];
  assign rel_r20     = rr[6];
  assign rel_r21     = rr[7];
  assign rel_r22     = rr[8];
  assign rel_shift_x = tr[0];
  assign rel_shift_y = tr[1];
  assign rel_shift_z = tr[2];

  // Checks
  `RPAA_ASSERT_IMPLIES(a_latency, clk, rst, done, $past(start, rpaa_pkg::TOTAL_LAT))
  `RPAA_ASSERT_NEVER(a_pose_sync, clk, rst, ctl1.valid != ctl2.valid)
  `RPAA_ASSERT_IMPLIES(a_r00_range, clk, rst, done, (rel_r00 <= 18'sd65536) && (rel_r00 >= -18'sd65536))
  `RPAA_ASSERT_IMPLIES(a_r22_range, clk, rst, done, (rel_r22 <= 18'sd65536) && (rel_r22 >= -18'sd65536))

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the relative pose pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam longint ONE = 64'sd1073741824;
  localparam longint TURN = 64'sd6746518852;
  localparam longint HALF_TURN = 64'sd3373259426;
  localparam longint QUARTER = 64'sd1686629713;
  localparam longint CORDIC_GAIN = 64'sd652032874;

  typedef struct {
    logic signed [17:0] r1 [3];
    logic signed [31:0] t1 [3];
    logic signed [17:0] r2 [3];
    logic signed [31:0] t2 [3];
  } pose_pair_t;

  typedef struct {
    logic signed [17:0] rot [9];
    logic signed [31:0] sh [3];
  } rel_pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic signed [17:0] first_rot_x = '0, first_rot_y = '0, first_rot_z = '0;
  logic signed [31:0] first_shift_x = '0, first_shift_y = '0, first_shift_z = '0;
  logic signed [17:0] second_rot_x = '0, second_rot_y = '0, second_rot_z = '0;
  logic signed [31:0] second_shift_x = '0, second_shift_y = '0, second_shift_z = '0;
  logic signed [17:0] rel_r00, rel_r01, rel_r02, rel_r10, rel_r11, rel_r12;
  logic signed [17:0] rel_r20, rel_r21, rel_r22;
  logic signed [31:0] rel_shift_x, rel_shift_y, rel_shift_z;

  rel_pose_t pending_poses[$];
  int mismatches = 0;
  int idle_pct = 0;
  longint cycles = 0;

  relative_pose_from_axis_angle dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Floor shift for signed 64-bit values
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r = 0, b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Rodrigues matrix in Q.30
  function automatic void rodrigues(input longint v [3], output longint m [3][3]);
    longint n2, theta, a, x, y, z, c, s, t, dx, dy;
    longint k [3];
    longint atan_tab [32];
    bit flip;
    n2 = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    flip = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? ONE : 0;
    if (n2 == 0) return;
    for (int i = 0; i < 32; i++) atan_tab[i] = longint'(rpaa_pkg::atan_q30(i));
    theta = int_sqrt(n2 <<< 4);
    a = theta * 16384;
    while (a > HALF_TURN) a -= TURN;
    if (a > QUARTER) begin
      a -= HALF_TURN; flip = 1;
    end else if (a < -QUARTER) begin
      a += HALF_TURN; flip = 1;
    end
    x = CORDIC_GAIN; y = 0; z = a;
    for (int i = 0; i < rpaa_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = ONE - c;
    for (int i = 0; i < 3; i++) k[i] = clip((v[i] <<< 32) / theta, -ONE, ONE);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        m[i][j] = fshr(t * fshr(k[i] * k[j], 30), 30);
        if (i == j) m[i][j] += c;
      end
    m[0][1] -= fshr(s * k[2], 30);
    m[0][2] += fshr(s * k[1], 30);
    m[1][0] += fshr(s * k[2], 30);
    m[1][2] -= fshr(s * k[0], 30);
    m[2][0] -= fshr(s * k[1], 30);
    m[2][1] += fshr(s * k[0], 30);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = clip(m[i][j], -ONE, ONE);
  endfunction

  function automatic rel_pose_t relative_pose(pose_pair_t p);
    longint v1 [3], v2 [3], a [3][3], b [3][3], rr [3][3];
    longint acc;
    rel_pose_t res;
    for (int i = 0; i < 3; i++) begin
      v1[i] = p.r1[i]; v2[i] = p.r2[i];
    end
    rodrigues(v1, a);
    rodrigues(v2, b);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int q = 0; q < 3; q++) acc += b[i][q] * a[j][q];
        rr[i][j] = clip(fshr(acc + (64'sd1 <<< 29), 30), -ONE, ONE);
        res.rot[i*3+j] = 18'(fshr(rr[i][j] + 8192, 14));
      end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int q = 0; q < 3; q++) acc += rr[i][q] * longint'(p.t1[q]);
      acc = longint'(p.t2[i]) - fshr(acc + (64'sd1 <<< 29), 30);
      res.sh[i] = 32'(clip(acc, -64'sd2147483648, 64'sd2147483647));
    end
    return res;
  endfunction

  // Drive one transaction and wait for acceptance
  task automatic send_pair(pose_pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    first_rot_x <= p.r1[0]; first_rot_y <= p.r1[1]; first_rot_z <= p.r1[2];
    first_shift_x <= p.t1[0]; first_shift_y <= p.t1[1]; first_shift_z <= p.t1[2];
    second_rot_x <= p.r2[0]; second_rot_y <= p.r2[1]; second_rot_z <= p.r2[2];
    second_shift_x <= p.t2[0]; second_shift_y <= p.t2[1]; second_shift_z <= p.t2[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_poses.push_back(relative_pose(p));
  endtask

  task automatic pause_send();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [17:0] rand_rot(int mode);
    case (mode)
      0: return 18'($urandom);
      1: return 18'($signed($urandom_range(8000)) - 4000);
      2: return 18'sd0;
      default: return $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_shift(int mode);
    case (mode)
      0: return 32'($urandom);
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  function automatic pose_pair_t random_pair();
    pose_pair_t p;
    int rm, sm;
    rm = $urandom_range(9) < 6 ? $urandom_range(1) : $urandom_range(3);
    sm = $urandom_range(9) < 7 ? $urandom_range(1) : 2;
    for (int i = 0; i < 3; i++) begin
      p.r1[i] = rand_rot(rm); p.r2[i] = rand_rot($urandom_range(3));
      p.t1[i] = rand_shift(sm); p.t2[i] = rand_shift($urandom_range(2));
    end
    if ($urandom_range(9) == 0) p.r1 = '{18'sd0, 18'sd0, 18'sd0};
    return p;
  endfunction

  // Field extremes, zero vectors, overflowing translations
  task automatic test_directed();
    pose_pair_t p;
    logic signed [17:0] rot_ext [5] = '{18'sd0, 18'sd1, -18'sd1, 18'sh1FFFF, 18'sh20000};
    logic signed [31:0] sh_ext [3] = '{32'sd0, 32'sh7FFFFFFF, 32'sh80000000};
    for (int n = 0; n < 20; n++) begin
      for (int i = 0; i < 3; i++) begin
        p.r1[i] = rot_ext[(n + i) % 5];
        p.r2[i] = rot_ext[(n * 2 + i) % 5];
        p.t1[i] = sh_ext[(n + i) % 3];
        p.t2[i] = sh_ext[(n + 2 * i + 1) % 3];
      end
      send_pair(p);
    end
    // identity both sides, and a half-turn about x
    p.r1 = '{18'sd0, 18'sd0, 18'sd0}; p.r2 = p.r1;
    p.t1 = '{32'sd65536, -32'sd65536, 32'sd7}; p.t2 = '{32'sd1, 32'sd2, 32'sd3};
    send_pair(p);
    p.r2 = '{18'sd51472, 18'sd0, 18'sd0};
    send_pair(p);
    pause_send();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int n = 0; n < count; n++) send_pair(random_pair());
    pause_send();
  endtask

  // Sender holds off until the pipeline has drained
  task automatic test_drain_pause();
    while (pending_poses.size() != 0) @(posedge clk);
    idle_pct = 0;
    for (int n = 0; n < 10; n++) send_pair(random_pair());
    pause_send();
  endtask

  // Result checker
  always @(posedge clk) begin
    rel_pose_t want;
    rel_pose_t got;
    bit bad;
    if (!rst && done) begin
      got.rot = '{rel_r00, rel_r01, rel_r02, rel_r10, rel_r11, rel_r12,
                  rel_r20, rel_r21, rel_r22};
      got.sh = '{rel_shift_x, rel_shift_y, rel_shift_z};
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
      end else begin
        want = pending_poses.pop_front();
        bad = 0;
        for (int i = 0; i < 9; i++) if (got.rot[i] !== want.rot[i]) bad = 1;
        for (int i = 0; i < 3; i++) if (got.sh[i] !== want.sh[i]) bad = 1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            for (int i = 0; i < 9; i++)
              $display("r%0d expected %0d got %0d", i, want.rot[i], got.rot[i]);
            for (int i = 0; i < 3; i++)
              $display("t%0d expected %0d got %0d", i, want.sh[i], got.sh[i]);
          end
        end
      end
    end
  end

  // Run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(150, 16);
    test_drain_pause();
    test_random(150, 71);
    test_random(150, 0);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (rpaa_pkg::TOTAL_LAT + 20) @(posedge clk);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
